FILE: rtl/core/hds_pkg.sv
package hds_pkg;

    localparam int PIXEL_W = 8;
    localparam int DET_W = 24;
    localparam int ROW_W = 12;
    localparam int COL_OUT_W = 11;
    localparam int CFG_W = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int MAX_WIDTH_DEFAULT = 2048;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic                 emit;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] column;
        logic                 last;
    } pos_t;

endpackage

FILE: rtl/core/hessian_determinant_stream.sv
// Channel  Direction  Handshake                       Payload
// s_axis   in         s_axis_tvalid / s_axis_tready   tdata: pixel
// m_axis   out        m_axis_tvalid / m_axis_tready   tdata: determinant, row, column;
//                                                     tlast: frame_last
// cfg      in         cfg_we                          cfg_index, cfg_data
//
// One pixel is taken in every cycle unless a result stall holds the pixel stage. The
// pixel stage registers the pixel and its line buffer reads together, and the
// determinant is formed between that stage and the result register.
// Reset clears the counters, the window and the valid flags; the line buffers are not
// cleared, as every entry that feeds a result is written in a frame before it is read.
// A stalled result holds the pixel stage only if that pixel also produces a result.
module hessian_determinant_stream #(
    parameter int MAX_WIDTH = hds_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [hds_pkg::PIXEL_W-1:0]        s_axis_tdata,   // [7:0] pixel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [23:0] determinant, [35:24] row, [46:36] column, [47] zero
    output logic [hds_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,   // frame_last
    input  logic                               cfg_we,
    input  logic [hds_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hds_pkg::CFG_W-1:0]          cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                                in_accept;
    logic                                s1_advance;
    logic [COL_W-1:0]                    col;
    hds_pkg::pos_t                       pos;

    logic                                s1_valid_reg;
    logic [hds_pkg::PIXEL_W-1:0]         s1_pixel_reg;
    logic [COL_W-1:0]                    s1_col_reg;
    hds_pkg::pos_t                       s1_pos_reg;

    logic [hds_pkg::PIXEL_W-1:0]         top;
    logic [hds_pkg::PIXEL_W-1:0]         mid;
    logic signed [hds_pkg::DET_W-1:0]    det;

    logic                                out_valid_reg;
    logic [hds_pkg::DET_W-1:0]           out_det_reg;
    logic [hds_pkg::ROW_W-1:0]           out_row_reg;
    logic [hds_pkg::COL_OUT_W-1:0]       out_col_reg;
    logic                                out_last_reg;

    assign s1_advance = s1_valid_reg && (!s1_pos_reg.emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    hds_raster_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_accept),
        .col       (col),
        .pos       (pos)
    );

    hds_ram #(
        .DATA_W (hds_pkg::PIXEL_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_upper (
        .clk     (clk),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data (mid),
        .rd_en   (in_accept),
        .rd_addr (col),
        .rd_data (top)
    );

    hds_ram #(
        .DATA_W (hds_pkg::PIXEL_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_middle (
        .clk     (clk),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (in_accept),
        .rd_addr (col),
        .rd_data (mid)
    );

    hds_kernel u_kernel (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (s1_advance),
        .top   (top),
        .mid   (mid),
        .bot   (s1_pixel_reg),
        .det   (det)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance && s1_pos_reg.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= s_axis_tdata;
            s1_col_reg   <= col;
            s1_pos_reg   <= pos;
        end
        if (s1_advance && s1_pos_reg.emit)
        begin
            out_det_reg  <= det;
            out_row_reg  <= s1_pos_reg.row;
            out_col_reg  <= s1_pos_reg.column;
            out_last_reg <= s1_pos_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {1'b0, out_col_reg, out_row_reg, out_det_reg};
    assign m_axis_tlast = out_last_reg;

`ifndef SYNTH
    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_pos_reg.emit) |=> m_axis_tvalid)
        else $error("Result from the pixel stage did not reach the output register.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && s1_pos_reg.emit && m_axis_tvalid && !m_axis_tready))
        else $error("Input stalled without a blocked result.");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("Pixel stage changed while it was held.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !(s1_advance && s1_pos_reg.emit))
        else $error("Waiting result overwritten.");
`endif

endmodule

FILE: rtl/core/hds_ram.sv
module hds_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/hds_raster_ctrl.sv
module hds_raster_ctrl #(
    parameter int MAX_WIDTH = hds_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hds_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hds_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             advance,
    output logic [$clog2(MAX_WIDTH)-1:0]     col,
    output hds_pkg::pos_t                    pos
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WID_W > hds_pkg::CFG_W) ? WID_W : hds_pkg::CFG_W;
    localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] MIN_W = CMP_W'(3);
    localparam logic [hds_pkg::ROW_W-1:0] MIN_H = hds_pkg::ROW_W'(3);

    logic [hds_pkg::CFG_W-1:0] frame_width_reg;
    logic [hds_pkg::CFG_W-1:0] frame_height_reg;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [hds_pkg::ROW_W-1:0] row_reg, row_next;
    logic [CMP_W-1:0]          width_eff;
    logic [CMP_W-1:0]          col_plus;
    logic [hds_pkg::ROW_W-1:0] height_eff;
    logic [hds_pkg::ROW_W:0]   row_plus;
    logic                      cfg_hit;
    logic                      row_end;
    logic                      frame_end;

    always_comb
    begin
        width_eff = CMP_W'(frame_width_reg);
        if (width_eff < MIN_W)
        begin
            width_eff = MIN_W;
        end
        else if (width_eff > MAX_W)
        begin
            width_eff = MAX_W;
        end
        height_eff = (frame_height_reg < MIN_H) ? MIN_H : frame_height_reg;
    end

    assign col_plus = CMP_W'(col_reg) + CMP_W'(1);
    assign row_plus = {1'b0, row_reg} + (hds_pkg::ROW_W+1)'(1);
    assign row_end = (col_plus >= width_eff);
    assign frame_end = (row_plus >= {1'b0, height_eff});

    always_comb
    begin
        cfg_hit = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                hds_pkg::CFG_FRAME_WIDTH:  cfg_hit = 1'b1;
                hds_pkg::CFG_FRAME_HEIGHT: cfg_hit = 1'b1;
                default:                   cfg_hit = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (advance)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_plus[hds_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_plus[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= hds_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= hds_pkg::FRAME_HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == hds_pkg::CFG_FRAME_WIDTH))
            begin
                frame_width_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == hds_pkg::CFG_FRAME_HEIGHT))
            begin
                frame_height_reg <= cfg_data;
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;
    assign pos.emit = (row_reg >= hds_pkg::ROW_W'(2)) && (col_reg >= COL_W'(2));
    assign pos.row = row_reg - hds_pkg::ROW_W'(1);
    assign pos.column = hds_pkg::COL_OUT_W'(CMP_W'(col_reg) - CMP_W'(1));
    assign pos.last = row_end && frame_end;

endmodule

FILE: rtl/core/hds_kernel.sv
module hds_kernel (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              shift,
    input  logic [hds_pkg::PIXEL_W-1:0]       top,
    input  logic [hds_pkg::PIXEL_W-1:0]       mid,
    input  logic [hds_pkg::PIXEL_W-1:0]       bot,
    output logic signed [hds_pkg::DET_W-1:0]  det
);

    localparam int PW = hds_pkg::PIXEL_W;
    localparam int DW = PW + 3;
    localparam int PRW = 2 * DW;
    localparam int FW = PRW + 5;

    logic [PW-1:0] t0_reg, m0_reg, b0_reg;
    logic [PW-1:0] t1_reg, m1_reg, b1_reg;

    logic signed [DW-1:0]  lxx, lyy, lxy4;
    logic signed [PRW-1:0] pxx, pxy;
    logic signed [FW-1:0]  det_full;

    // Window holds the two columns before the current one: top, middle, bottom.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_reg <= '0;
            m0_reg <= '0;
            b0_reg <= '0;
            t1_reg <= '0;
            m1_reg <= '0;
            b1_reg <= '0;
        end
        else if (shift)
        begin
            t0_reg <= t1_reg;
            m0_reg <= m1_reg;
            b0_reg <= b1_reg;
            t1_reg <= top;
            m1_reg <= mid;
            b1_reg <= bot;
        end
    end

    assign lxx = $signed(DW'(m0_reg)) - ($signed(DW'(m1_reg)) <<< 1) + $signed(DW'(mid));
    assign lyy = $signed(DW'(t1_reg)) - ($signed(DW'(m1_reg)) <<< 1) + $signed(DW'(b1_reg));
    assign lxy4 = $signed(DW'(t0_reg)) - $signed(DW'(top)) + $signed(DW'(bot))
                - $signed(DW'(b0_reg));
    assign pxx = PRW'(lxx) * PRW'(lyy);
    assign pxy = PRW'(lxy4) * PRW'(lxy4);
    assign det_full = (FW'(pxx) <<< 4) - FW'(pxy);
    assign det = det_full[hds_pkg::DET_W-1:0];

endmodule
